FILE: sv/parbt_pkg.sv
`default_nettype none

package parbt_pkg;

	// Field and port widths
	localparam int AMOUNT_W   = 64;
	localparam int COUNT_W    = 32;
	localparam int MODE_W     = 3;
	localparam int SLOT_W     = 4;
	localparam int KIND_W     = 3;
	localparam int CFG_ADDR_W = 6;
	localparam int CFG_DATA_W = 64;

	// Request modes
	localparam logic [MODE_W-1:0] MODE_REGISTER   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_UNREGISTER = 3'd1;
	localparam logic [MODE_W-1:0] MODE_SET_LIMIT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ALLOC      = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RELEASE    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd5;

	// Configuration register indexes, also the resource kind codes
	localparam logic [2:0] CFG_CPU   = 3'd0;
	localparam logic [2:0] CFG_RAM   = 3'd1;
	localparam logic [2:0] CFG_TOKEN = 3'd2;
	localparam logic [2:0] CFG_CALL  = 3'd3;
	localparam logic [2:0] CFG_TIME  = 3'd4;

	// Global limit reset values
	localparam logic [12:0] CPU_LIMIT_RST   = 13'd8;
	localparam logic [63:0] RAM_LIMIT_RST   = 64'd17179869184;
	localparam logic [31:0] TOKEN_LIMIT_RST = 32'd128000;
	localparam logic [31:0] CALL_LIMIT_RST  = 32'd1000;
	localparam logic [31:0] TIME_LIMIT_RST  = 32'd3600000;

	// Classified operation carried from front to back
	typedef enum logic [2:0] {
		OP_REGISTER,
		OP_UNREGISTER,
		OP_SET_LIMIT,
		OP_ALLOC,
		OP_RELEASE,
		OP_QUERY,
		OP_REPORT
	} op_kind_t;

	typedef struct packed {
		op_kind_t              op;
		logic [SLOT_W-1:0]     slot;
		logic [KIND_W-1:0]     kind;
		logic                  slot_ok;
		logic                  kind_ok;
		logic [AMOUNT_W-1:0]   amount;
	} item_t;

	// Global limits as held by the configuration registers
	typedef struct packed {
		logic [12:0] cpu;
		logic [63:0] ram;
		logic [31:0] token;
		logic [31:0] call;
		logic [31:0] tlim;
	} glim_t;

	// One budget table entry
	typedef struct packed {
		logic [AMOUNT_W-1:0] limit;
		logic [AMOUNT_W-1:0] used;
		logic [AMOUNT_W-1:0] peak;
	} entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EXEC,
		BK_SWEEP,
		BK_DONE
	} back_state_t;

	// Global limit of a kind; kinds without a register have none
	function automatic logic [AMOUNT_W-1:0] glim_of(glim_t g, logic [2:0] k);
		logic [AMOUNT_W-1:0] r;
		case (k)
			CFG_CPU:   r = AMOUNT_W'(g.cpu);
			CFG_RAM:   r = g.ram;
			CFG_TOKEN: r = AMOUNT_W'(g.token);
			CFG_CALL:  r = AMOUNT_W'(g.call);
			CFG_TIME:  r = AMOUNT_W'(g.tlim);
			default:   r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/parbt_in_if.sv
`default_nettype none

interface parbt_in_if;
	logic                            valid;
	logic                            ready;
	logic [parbt_pkg::MODE_W-1:0]    mode;
	logic [parbt_pkg::SLOT_W-1:0]    agent_slot;
	logic [parbt_pkg::KIND_W-1:0]    resource_kind;
	logic [parbt_pkg::AMOUNT_W-1:0]  amount;

	modport source (output valid, mode, agent_slot, resource_kind, amount, input ready);
	modport sink (input valid, mode, agent_slot, resource_kind, amount, output ready);
endinterface

`default_nettype wire

FILE: sv/parbt_out_if.sv
`default_nettype none

interface parbt_out_if;
	logic                            valid;
	logic                            ready;
	logic                            ok;
	logic [parbt_pkg::AMOUNT_W-1:0]  used_amount;
	logic [parbt_pkg::AMOUNT_W-1:0]  available_amount;
	logic [parbt_pkg::AMOUNT_W-1:0]  peak_amount;
	logic [parbt_pkg::AMOUNT_W-1:0]  global_used;
	logic [parbt_pkg::COUNT_W-1:0]   registered_count;
	logic [parbt_pkg::COUNT_W-1:0]   denied_count;
	logic [parbt_pkg::COUNT_W-1:0]   alloc_count;
	logic [parbt_pkg::COUNT_W-1:0]   release_count;

	modport source (output valid, ok, used_amount, available_amount, peak_amount, global_used,
		registered_count, denied_count, alloc_count, release_count, input ready);
	modport sink (input valid, ok, used_amount, available_amount, peak_amount, global_used,
		registered_count, denied_count, alloc_count, release_count, output ready);
endinterface

`default_nettype wire

FILE: sv/parbt_cfg.sv
`default_nettype none

module parbt_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [parbt_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [parbt_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic      [parbt_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                                    pready,
	output parbt_pkg::glim_t                        glim
);
	import parbt_pkg::*;

	glim_t       glim_q;
	logic [2:0]  reg_idx;
	logic        wr_en;

	// Registers sit on 8-byte boundaries
	assign reg_idx = paddr[5:3];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign glim    = glim_q;

	// Write the addressed global limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glim_q.cpu   <= CPU_LIMIT_RST;
			glim_q.ram   <= RAM_LIMIT_RST;
			glim_q.token <= TOKEN_LIMIT_RST;
			glim_q.call  <= CALL_LIMIT_RST;
			glim_q.tlim  <= TIME_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				CFG_CPU:   glim_q.cpu   <= pwdata[12:0];
				CFG_RAM:   glim_q.ram   <= pwdata;
				CFG_TOKEN: glim_q.token <= pwdata[31:0];
				CFG_CALL:  glim_q.call  <= pwdata[31:0];
				CFG_TIME:  glim_q.tlim  <= pwdata[31:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		prdata = glim_of(glim_q, reg_idx);
	end

endmodule

`default_nettype wire

FILE: sv/parbt_front.sv
`default_nettype none

module parbt_front #(
	parameter int AGENT_SLOTS    = 16,
	parameter int RESOURCE_KINDS = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	parbt_in_if.sink           req,
	output logic               deq_valid,
	input  wire logic          deq_ready,
	output parbt_pkg::item_t   deq_item
);
	import parbt_pkg::*;

	item_t       cls_item;
	item_t       q_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;

	// Classify the incoming beat
	always_comb begin
		cls_item.slot    = req.agent_slot;
		cls_item.kind    = req.resource_kind;
		cls_item.amount  = req.amount;
		cls_item.slot_ok = int'(req.agent_slot) < AGENT_SLOTS;
		cls_item.kind_ok = int'(req.resource_kind) < RESOURCE_KINDS;
		unique case (req.mode)
			MODE_REGISTER:   cls_item.op = OP_REGISTER;
			MODE_UNREGISTER: cls_item.op = OP_UNREGISTER;
			MODE_SET_LIMIT:  cls_item.op = OP_SET_LIMIT;
			MODE_ALLOC:      cls_item.op = OP_ALLOC;
			MODE_RELEASE:    cls_item.op = OP_RELEASE;
			MODE_QUERY:      cls_item.op = OP_QUERY;
			default:         cls_item.op = OP_REPORT;
		endcase
		// Slot out of range acts in no mode; kind out of range acts only in register and unregister
		if (!cls_item.slot_ok) begin
			cls_item.op = OP_REPORT;
		end else if (!cls_item.kind_ok && cls_item.op != OP_REGISTER
				&& cls_item.op != OP_UNREGISTER) begin
			cls_item.op = OP_REPORT;
		end
	end

	// Two-entry queue toward the back end
	assign req.ready = cnt_q != 2'd2;
	assign push      = req.valid && req.ready;
	assign deq_valid = cnt_q != 2'd0;
	assign pop       = deq_valid && deq_ready;
	assign deq_item  = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue fill count out of range");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cnt_q == 2'($past(cnt_q) + {1'b0, $past(push)} - {1'b0, $past(pop)}))
		else $error("queue fill count does not follow push and pop");

endmodule

`default_nettype wire

FILE: sv/parbt_back.sv
`default_nettype none

module parbt_back #(
	parameter int AGENT_SLOTS    = 16,
	parameter int RESOURCE_KINDS = 5
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire parbt_pkg::glim_t glim,
	input  wire logic          deq_valid,
	output logic               deq_ready,
	input  wire parbt_pkg::item_t deq_item,
	parbt_out_if.source        rsp
);
	import parbt_pkg::*;

	localparam int SW    = (AGENT_SLOTS > 1) ? $clog2(AGENT_SLOTS) : 1;
	localparam int KW    = (RESOURCE_KINDS > 1) ? $clog2(RESOURCE_KINDS) : 1;
	localparam int AW    = SW + KW;
	localparam int DEPTH = 1 << AW;

	back_state_t           state_q, state_d;
	item_t                 item_q;
	entry_t                mem [DEPTH];
	entry_t                rd_q;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	entry_t                wr_data;
	logic [KW-1:0]         sweep_q;
	logic                  sweep_last;
	logic [SW-1:0]         slot_idx;
	logic [KW-1:0]         kind_idx;
	logic [AGENT_SLOTS-1:0] valid_q;
	logic [AMOUNT_W-1:0]   ku_q [RESOURCE_KINDS];
	logic [COUNT_W-1:0]    reg_total_q, deny_total_q, alloc_total_q, rel_total_q;

	// Execute-step results
	logic                  live;
	logic [AMOUNT_W-1:0]   amt;
	logic [AMOUNT_W-1:0]   ku_cur;
	logic [AMOUNT_W:0]     sum;
	logic                  fits;
	logic [AMOUNT_W:0]     gsum;
	logic                  ex_ok, ex_vis, ex_wr, ex_ku_wr, ex_clr;
	logic                  ex_alloc, ex_deny, ex_rel;
	entry_t                ex_entry;
	logic [AMOUNT_W-1:0]   ex_ku;

	// Pending result, held until the output register takes it
	logic                  res_ok_q;
	logic                  res_vis_q;
	entry_t                res_entry_q;
	logic                  out_load;
	logic [AMOUNT_W-1:0]   avail;

	logic                  out_valid_q;
	logic                  out_ok_q;
	logic [AMOUNT_W-1:0]   out_used_q, out_avail_q, out_peak_q, out_glob_q;
	logic [COUNT_W-1:0]    out_reg_q, out_deny_q, out_alloc_q, out_rel_q;

	assign slot_idx   = SW'(item_q.slot);
	assign kind_idx   = KW'(item_q.kind);
	assign sweep_last = sweep_q == KW'(RESOURCE_KINDS - 1);
	assign rd_addr    = {SW'(deq_item.slot), KW'(deq_item.kind)};
	assign amt        = item_q.amount;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (deq_valid) begin
					state_d = (deq_item.op == OP_REGISTER) ? BK_SWEEP : BK_EXEC;
				end
			end
			BK_EXEC: state_d = BK_DONE;
			BK_SWEEP: begin
				if (sweep_last) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_load) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		deq_ready = 1'b0;
		rd_en     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				deq_ready = 1'b1;
				rd_en     = deq_valid;
			end
			BK_DONE: out_load = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Work out the operation on the entry just read
	always_comb begin
		live     = item_q.slot_ok && valid_q[slot_idx];
		ku_cur   = item_q.kind_ok ? ku_q[kind_idx] : '0;
		sum      = {1'b0, rd_q.used} + {1'b0, amt};
		fits     = !sum[AMOUNT_W] && (sum[AMOUNT_W-1:0] <= rd_q.limit);
		gsum     = {1'b0, ku_cur} + {1'b0, amt};
		ex_ok    = 1'b0;
		ex_vis   = item_q.slot_ok && item_q.kind_ok && valid_q[slot_idx];
		ex_wr    = 1'b0;
		ex_ku_wr = 1'b0;
		ex_clr   = 1'b0;
		ex_alloc = 1'b0;
		ex_deny  = 1'b0;
		ex_rel   = 1'b0;
		ex_entry = rd_q;
		ex_ku    = ku_cur;
		case (item_q.op)
			OP_UNREGISTER: begin
				ex_ok  = live;
				ex_vis = 1'b0;
				ex_clr = 1'b1;
			end
			OP_SET_LIMIT: begin
				if (live) begin
					ex_entry.limit = amt;
					ex_wr          = 1'b1;
					ex_ok          = 1'b1;
				end
			end
			OP_ALLOC: begin
				if (live && fits) begin
					ex_entry.used = sum[AMOUNT_W-1:0];
					if (sum[AMOUNT_W-1:0] > rd_q.peak) begin
						ex_entry.peak = sum[AMOUNT_W-1:0];
					end
					ex_ku    = gsum[AMOUNT_W] ? '1 : gsum[AMOUNT_W-1:0];
					ex_wr    = 1'b1;
					ex_ku_wr = 1'b1;
					ex_alloc = 1'b1;
					ex_ok    = 1'b1;
				end else if (live) begin
					ex_deny = 1'b1;
				end
			end
			OP_RELEASE: begin
				if (live) begin
					ex_entry.used = (rd_q.used > amt) ? rd_q.used - amt : '0;
					ex_ku         = (ku_cur > amt) ? ku_cur - amt : '0;
					ex_wr         = 1'b1;
					ex_ku_wr      = 1'b1;
					ex_rel        = 1'b1;
					ex_ok         = 1'b1;
				end
			end
			OP_QUERY: ex_ok = live && fits;
			default: ;
		endcase
	end

	// Table port: one write, one registered read
	always_comb begin
		if (state_q == BK_SWEEP) begin
			wr_en         = 1'b1;
			wr_addr       = {slot_idx, sweep_q};
			wr_data.limit = glim_of(glim, 3'(sweep_q)) >> 2;
			wr_data.used  = '0;
			wr_data.peak  = '0;
		end else begin
			wr_en   = (state_q == BK_EXEC) && ex_wr;
			wr_addr = {slot_idx, kind_idx};
			wr_data = ex_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Hold the item and its pending result
	always_ff @(posedge clk) begin
		if (rd_en) begin
			item_q <= deq_item;
		end
		if (state_q == BK_EXEC) begin
			res_ok_q    <= ex_ok;
			res_vis_q   <= ex_vis;
			res_entry_q <= ex_entry;
		end else if (state_q == BK_SWEEP && sweep_last) begin
			res_ok_q          <= 1'b1;
			res_vis_q         <= item_q.kind_ok;
			res_entry_q.limit <= glim_of(glim, item_q.kind) >> 2;
			res_entry_q.used  <= '0;
			res_entry_q.peak  <= '0;
		end
	end

	// Update valid bits, global usage and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q       <= '0;
			valid_q       <= '0;
			reg_total_q   <= '0;
			deny_total_q  <= '0;
			alloc_total_q <= '0;
			rel_total_q   <= '0;
			for (int i = 0; i < RESOURCE_KINDS; i++) begin
				ku_q[i] <= '0;
			end
		end else begin
			if (state_q == BK_SWEEP) begin
				sweep_q <= sweep_q + 1'b1;
				if (sweep_last) begin
					valid_q[slot_idx] <= 1'b1;
					reg_total_q       <= reg_total_q + 32'd1;
				end
			end else begin
				sweep_q <= '0;
			end
			if (state_q == BK_EXEC) begin
				if (ex_clr) begin
					valid_q[slot_idx] <= 1'b0;
				end
				if (ex_ku_wr) begin
					ku_q[kind_idx] <= ex_ku;
				end
				if (ex_alloc) begin
					alloc_total_q <= alloc_total_q + 32'd1;
				end
				if (ex_deny) begin
					deny_total_q <= deny_total_q + 32'd1;
				end
				if (ex_rel) begin
					rel_total_q <= rel_total_q + 32'd1;
				end
			end
		end
	end

	// Output register
	assign avail = (res_entry_q.limit > res_entry_q.used) ?
		res_entry_q.limit - res_entry_q.used : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q    <= res_ok_q;
			out_used_q  <= res_vis_q ? res_entry_q.used : '0;
			out_avail_q <= res_vis_q ? avail : '0;
			out_peak_q  <= res_vis_q ? res_entry_q.peak : '0;
			out_glob_q  <= item_q.kind_ok ? ku_q[kind_idx] : '0;
			out_reg_q   <= reg_total_q;
			out_deny_q  <= deny_total_q;
			out_alloc_q <= alloc_total_q;
			out_rel_q   <= rel_total_q;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.ok               = out_ok_q;
	assign rsp.used_amount      = out_used_q;
	assign rsp.available_amount = out_avail_q;
	assign rsp.peak_amount      = out_peak_q;
	assign rsp.global_used      = out_glob_q;
	assign rsp.registered_count = out_reg_q;
	assign rsp.denied_count     = out_deny_q;
	assign rsp.alloc_count      = out_alloc_q;
	assign rsp.release_count    = out_rel_q;

	a_exec_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_EXEC |=> state_q == BK_DONE)
		else $error("execute step lasted more than one cycle");

	a_sweep_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SWEEP && !sweep_last |=>
			state_q == BK_SWEEP && sweep_q == KW'($past(sweep_q) + 1'b1))
		else $error("register sweep skipped a kind");

	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SWEEP && sweep_last |=>
			valid_q[$past(slot_idx)] && reg_total_q == $past(reg_total_q) + 32'd1)
		else $error("register sweep ended without marking the slot");

endmodule

`default_nettype wire

FILE: sv/per_agent_resource_budget_table.sv
// Channel  Dir  Protocol        Payload
// req      in   valid/ready     mode, agent_slot, resource_kind, amount
// rsp      out  valid/ready     ok, used/available/peak, global_used, four counters
// cfg      in   APB, 64-bit     five global limits at byte address 8*i
//
// A request beat passes the execution unit in three steps (table read, execute and
// write back, result hand-off); register instead sweeps the kinds with one table
// write per kind before the hand-off. Reset clears valid bits, global usage and
// counters; table entries are not reset but written by register, and entries of
// unregistered slots are not reported. A two-beat queue keeps req open while
// the execution unit waits on a stalled rsp.
`default_nettype none

module per_agent_resource_budget_table #(
	parameter int AGENT_SLOTS    = 16,
	parameter int RESOURCE_KINDS = 5
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [parbt_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [parbt_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic      [parbt_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                                    pready,
	parbt_in_if.sink                                req,
	parbt_out_if.source                             rsp
);
	import parbt_pkg::*;

	glim_t  glim;
	logic   deq_valid;
	logic   deq_ready;
	item_t  deq_item;

	parbt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.glim    (glim)
	);

	parbt_front #(
		.AGENT_SLOTS    (AGENT_SLOTS),
		.RESOURCE_KINDS (RESOURCE_KINDS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq_item  (deq_item)
	);

	parbt_back #(
		.AGENT_SLOTS    (AGENT_SLOTS),
		.RESOURCE_KINDS (RESOURCE_KINDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.glim      (glim),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq_item  (deq_item),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
